### rtl/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg: shared types and constants for the quaternion to Euler angles core
// Fixed-point widths, the CORDIC arctangent table and the Q2.13 output rounding.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int IN_W         = 16;
  localparam int PROD_W       = 32;   // Q1.15 x Q1.15, 30 fraction bits
  localparam int SUM_W        = 34;   // doubled sums of products
  localparam int RAD_W        = 33;   // clamped pitch radicand
  localparam int ROOT_W       = 32;   // square root, 30 fraction bits
  localparam int REM_W        = 36;   // square root partial remainder
  localparam int VEC_W        = 36;   // CORDIC vector with gain headroom
  localparam int ANG_W        = 20;   // angle, 16 fraction bits
  localparam int SQRT_STEPS   = 32;
  localparam int CORDIC_STEPS = 17;
  // products, sums, square root, fold, micro-rotations, output register
  localparam int LATENCY      = 4 + SQRT_STEPS + CORDIC_STEPS;

  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic [RAD_W-1:0]        rad_t;
  typedef logic [ROOT_W-1:0]       root_t;
  typedef logic signed [15:0]      outang_t;

  localparam logic signed [SUM_W-1:0] ONE_Q30     = 34'sh0_4000_0000;
  localparam ang_t                    ANG_HALF_PI = 20'sd102944;
  localparam outang_t                 OUT_PI      = 16'sd25736;
  localparam outang_t                 OUT_HALF_PI = 16'sd12868;

  // atan(2^-i) with 16 fraction bits
  function automatic ang_t atan_entry(input int unsigned i);
    ang_t a;
    case (i)
      0:       a = 20'sd51472;
      1:       a = 20'sd30386;
      2:       a = 20'sd16055;
      3:       a = 20'sd8150;
      4:       a = 20'sd4091;
      5:       a = 20'sd2047;
      6:       a = 20'sd1024;
      7:       a = 20'sd512;
      8:       a = 20'sd256;
      9:       a = 20'sd128;
      10:      a = 20'sd64;
      11:      a = 20'sd32;
      12:      a = 20'sd16;
      13:      a = 20'sd8;
      14:      a = 20'sd4;
      15:      a = 20'sd2;
      16:      a = 20'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Round 16 fraction bits to 13, half up, then clamp to +/- lim
  function automatic outang_t to_q13(input logic signed [ANG_W:0] a, input outang_t lim);
    logic signed [ANG_W+1:0] s;
    logic signed [ANG_W+1:0] r;
    logic signed [ANG_W+1:0] l;
    s = (ANG_W+2)'(a) + 22'sd4;
    r = s >>> 3;
    l = (ANG_W+2)'(lim);
    if (r > l) r = l;
    if (r < -l) r = -l;
    return r[15:0];
  endfunction

endpackage

### rtl/qte_sqrt.sv
// ----------------------------------------------------------------------------
// qte_sqrt: pipelined integer square root
// One result bit per stage; gives floor(sqrt(rad * 2^30)).
// ----------------------------------------------------------------------------
module qte_sqrt import qte_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  rad_t  rad,
  output logic  out_valid,
  output root_t root
);

  logic               vs   [0:SQRT_STEPS];
  logic [63:0]        ns   [0:SQRT_STEPS];
  logic [REM_W-1:0]   rems [0:SQRT_STEPS];
  root_t              roots[0:SQRT_STEPS];

  // Load the radicand scaled by 2^30
  assign vs[0]    = in_valid;
  assign ns[0]    = {1'b0, rad, 30'b0};
  assign rems[0]  = '0;
  assign roots[0] = '0;

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic [REM_W-1:0] rem_next;
    root_t            root_next;

    // Bring down two radicand bits and try the next root bit
    always_comb begin
      rem_sh = {rems[j][REM_W-3:0], ns[j][63:62]};
      trial  = {2'b00, roots[j], 2'b01};
      if (rem_sh >= trial) begin
        rem_next  = rem_sh - trial;
        root_next = {roots[j][ROOT_W-2:0], 1'b1};
      end else begin
        rem_next  = rem_sh;
        root_next = {roots[j][ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      ns[j+1]    <= {ns[j][61:0], 2'b00};
      rems[j+1]  <= rem_next;
      roots[j+1] <= root_next;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[j+1] <= 1'b0;
      end else begin
        vs[j+1] <= vs[j];
      end
    end
  end

  assign out_valid = vs[SQRT_STEPS];
  assign root      = roots[SQRT_STEPS];

endmodule

### rtl/qte_cordic.sv
// ----------------------------------------------------------------------------
// qte_cordic: pipelined vectoring CORDIC arctangent
// Quadrant fold stage, then one micro-rotation per stage; 16 fraction bits out.
// ----------------------------------------------------------------------------
module qte_cordic import qte_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  vec_t y_in,
  input  vec_t x_in,
  output logic out_valid,
  output ang_t angle
);

  logic vs[0:CORDIC_STEPS];
  logic zf[0:CORDIC_STEPS];
  vec_t xs[0:CORDIC_STEPS];
  vec_t ys[0:CORDIC_STEPS];
  ang_t zs[0:CORDIC_STEPS];

  // Fold the left half plane by a quarter turn, flag the zero vector
  always_ff @(posedge clk) begin
    zf[0] <= (x_in == '0) && (y_in == '0);
    if (x_in < 0) begin
      if (y_in >= 0) begin
        xs[0] <= y_in;
        ys[0] <= -x_in;
        zs[0] <= ANG_HALF_PI;
      end else begin
        xs[0] <= -y_in;
        ys[0] <= x_in;
        zs[0] <= -ANG_HALF_PI;
      end
    end else begin
      xs[0] <= x_in;
      ys[0] <= y_in;
      zs[0] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else begin
      vs[0] <= in_valid;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    vec_t xsh;
    vec_t ysh;
    assign xsh = xs[i] >>> i;
    assign ysh = ys[i] >>> i;

    // Rotate toward the x axis and accumulate the angle
    always_ff @(posedge clk) begin
      zf[i+1] <= zf[i];
      if (ys[i] > 0) begin
        xs[i+1] <= xs[i] + ysh;
        ys[i+1] <= ys[i] - xsh;
        zs[i+1] <= zs[i] + atan_entry(i);
      end else begin
        xs[i+1] <= xs[i] - ysh;
        ys[i+1] <= ys[i] + xsh;
        zs[i+1] <= zs[i] - atan_entry(i);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else begin
        vs[i+1] <= vs[i];
      end
    end
  end

  assign out_valid = vs[CORDIC_STEPS];
  assign angle     = zf[CORDIC_STEPS] ? '0 : zs[CORDIC_STEPS];

endmodule

### rtl/quaternion_to_euler_angles_core.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_core: unit quaternion to ZYX roll, pitch, yaw
// Fully pipelined; one quaternion in and one angle triple out per cycle.
// ----------------------------------------------------------------------------
// Takes one transaction per clock: busy is always low, so start may be held
// high every cycle. Each transaction returns roll and yaw (Q2.13 radians) and
// pitch (Q1.13 radians) with done high for one cycle, in order. The latency
// is set by the product and sum stages, the 32-stage square root for pitch,
// the 18-stage CORDIC and the output register; roll and yaw finish earlier
// and wait in a delay line. Results cannot be held off, so the receiver must
// take them.
module quaternion_to_euler_angles_core import qte_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [IN_W-1:0]  qw,
  input  logic signed [IN_W-1:0]  qx,
  input  logic signed [IN_W-1:0]  qy,
  input  logic signed [IN_W-1:0]  qz,
  output logic                    done,
  output logic signed [15:0]      roll,
  output logic signed [14:0]      pitch,
  output logic signed [15:0]      yaw
);

  logic                      v1, v2;
  logic signed [PROD_W-1:0]  wx, yz, xx, yy, wz, xy, zz, wy, xz;
  logic signed [SUM_W-1:0]   sr, cr, sy, cy;
  rad_t                      ra, rb;
  logic signed [SUM_W:0]     t2;
  logic signed [SUM_W:0]     ra_w, rb_w;
  logic                      rc_valid, yc_valid, pa_valid, pb_valid, pc_valid;
  ang_t                      roll_ang, yaw_ang, pitch_ang;
  root_t                     sa, sb;
  ang_t                      rdl[0:SQRT_STEPS-1];
  ang_t                      ydl[0:SQRT_STEPS-1];
  logic signed [ANG_W:0]     pitch_full;

  assign busy = 1'b0;

  // Stage 1: all products
  always_ff @(posedge clk) begin
    wx <= qw * qx;
    yz <= qy * qz;
    xx <= qx * qx;
    yy <= qy * qy;
    wz <= qw * qz;
    xy <= qx * qy;
    zz <= qz * qz;
    wy <= qw * qy;
    xz <= qx * qz;
  end

  // Pitch radicands 1 +/- 2t, clamped at zero
  always_comb begin
    t2   = ((SUM_W+1)'(wy) - (SUM_W+1)'(xz)) <<< 1;
    ra_w = (SUM_W+1)'(ONE_Q30) + t2;
    rb_w = (SUM_W+1)'(ONE_Q30) - t2;
  end

  // Stage 2: atan2 operands and radicands
  always_ff @(posedge clk) begin
    sr <= (SUM_W'(wx) + SUM_W'(yz)) <<< 1;
    cr <= ONE_Q30 - ((SUM_W'(xx) + SUM_W'(yy)) <<< 1);
    sy <= (SUM_W'(wz) + SUM_W'(xy)) <<< 1;
    cy <= ONE_Q30 - ((SUM_W'(yy) + SUM_W'(zz)) <<< 1);
    ra <= (ra_w < 0) ? '0 : ra_w[RAD_W-1:0];
    rb <= (rb_w < 0) ? '0 : rb_w[RAD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= start & ~busy;
      v2 <= v1;
    end
  end

  qte_cordic u_roll (
    .clk(clk), .rst(rst), .in_valid(v2),
    .y_in(VEC_W'(sr)), .x_in(VEC_W'(cr)),
    .out_valid(rc_valid), .angle(roll_ang)
  );

  qte_cordic u_yaw (
    .clk(clk), .rst(rst), .in_valid(v2),
    .y_in(VEC_W'(sy)), .x_in(VEC_W'(cy)),
    .out_valid(yc_valid), .angle(yaw_ang)
  );

  qte_sqrt u_sqrt_a (
    .clk(clk), .rst(rst), .in_valid(v2), .rad(ra),
    .out_valid(pa_valid), .root(sa)
  );

  qte_sqrt u_sqrt_b (
    .clk(clk), .rst(rst), .in_valid(v2), .rad(rb),
    .out_valid(pb_valid), .root(sb)
  );

  qte_cordic u_pitch (
    .clk(clk), .rst(rst), .in_valid(pa_valid),
    .y_in(VEC_W'(sa)), .x_in(VEC_W'(sb)),
    .out_valid(pc_valid), .angle(pitch_ang)
  );

  // Hold roll and yaw until pitch catches up
  always_ff @(posedge clk) begin
    rdl[0] <= roll_ang;
    ydl[0] <= yaw_ang;
    for (int k = 1; k < SQRT_STEPS; k++) begin
      rdl[k] <= rdl[k-1];
      ydl[k] <= ydl[k-1];
    end
  end

  assign pitch_full = ((ANG_W+1)'(pitch_ang) <<< 1) - (ANG_W+1)'(ANG_HALF_PI);

  // Output stage: round to Q2.13 and clamp
  always_ff @(posedge clk) begin
    roll  <= to_q13((ANG_W+1)'(rdl[SQRT_STEPS-1]), OUT_PI);
    pitch <= 15'(to_q13(pitch_full, OUT_HALF_PI));
    yaw   <= to_q13((ANG_W+1)'(ydl[SQRT_STEPS-1]), OUT_PI);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pc_valid;
    end
  end

  // Every accepted transaction comes out after a fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("result strobe missing after fixed latency");

  // Both square roots and both early arctangents run in lockstep
  a_lockstep: assert property (@(posedge clk) disable iff (rst)
    (pa_valid == pb_valid) && (rc_valid == yc_valid))
    else $error("parallel pipelines out of step");

  // The pitch path trails roll and yaw by the delay line length
  a_align: assert property (@(posedge clk) disable iff (rst)
    pc_valid |-> $past(rc_valid, SQRT_STEPS))
    else $error("pitch result not aligned with roll and yaw");

  // Clamped outputs stay in range
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (pitch <= 15'sd12868) && (pitch >= -15'sd12868) &&
             (roll <= OUT_PI) && (roll >= -OUT_PI) &&
             (yaw <= OUT_PI) && (yaw >= -OUT_PI))
    else $error("output angle out of range");

endmodule

### verif/tb_quaternion_to_euler_angles_core.sv
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_angles_core: self-checking bench for the Euler core
// Drives quaternions through the start/busy handshake, predicts roll, pitch
// and yaw with an independent fixed-point model and checks each done strobe.
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler_angles_core import qte_pkg::*; ();

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = LATENCY + 20;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
  } angles_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [15:0] qw, qx, qy, qz;
  logic done;
  logic signed [15:0] roll;
  logic signed [14:0] pitch;
  logic signed [15:0] yaw;

  angles_t angles_due[$];
  int      mismatch_cnt;
  int      cycle_cnt;
  bit      calm;

  quaternion_to_euler_angles_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .qw(qw), .qx(qx), .qy(qy), .qz(qz),
    .done(done), .roll(roll), .pitch(pitch), .yaw(yaw)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Integer square root, floor, bit by bit
  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Vectoring arctangent, 16 fraction bits
  function automatic longint vector_angle(input longint ay, input longint ax);
    longint ang;
    longint tmp;
    longint xs;
    longint ys;
    longint steps[17];
    steps = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
              128, 64, 32, 16, 8, 4, 2, 1};
    ang = 0;
    if (ax == 0 && ay == 0) return 0;
    if (ax < 0) begin
      if (ay >= 0) begin
        tmp = ay; ay = -ax; ax = tmp; ang = 102944;
      end else begin
        tmp = -ay; ay = ax; ax = tmp; ang = -102944;
      end
    end
    for (int i = 0; i < 17; i++) begin
      xs = ax >>> i;
      ys = ay >>> i;
      if (ay > 0) begin
        ax = ax + ys; ay = ay - xs; ang = ang + steps[i];
      end else begin
        ax = ax - ys; ay = ay + xs; ang = ang - steps[i];
      end
    end
    return ang;
  endfunction

  // Round to Q2.13 half up and clamp
  function automatic longint round_q13(input longint a, input longint lim);
    longint r;
    r = (a + 4) >>> 3;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic angles_t euler_of(input longint w, input longint x,
                                       input longint y, input longint z);
    angles_t res;
    longint  one;
    longint  t;
    longint  ra;
    longint  rb;
    longint  sa;
    longint  sb;
    one = 64'sd1 << 30;
    res.roll = 16'(round_q13(vector_angle(2 * (w * x + y * z),
                                          one - 2 * (x * x + y * y)), 25736));
    t  = w * y - x * z;
    ra = one + 2 * t;
    rb = one - 2 * t;
    if (ra < 0) ra = 0;
    if (rb < 0) rb = 0;
    sa = longint'(root_floor(longint'(ra) << 30));
    sb = longint'(root_floor(longint'(rb) << 30));
    res.pitch = 15'(round_q13(2 * vector_angle(sa, sb) - 102944, 12868));
    res.yaw = 16'(round_q13(vector_angle(2 * (w * z + x * y),
                                         one - 2 * (y * y + z * z)), 25736));
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatch_cnt++;
  endtask

  // Send one quaternion, with occasional idle cycles first unless calm is set
  task automatic send_quat(input logic [15:0] w, input logic [15:0] x,
                           input logic [15:0] y, input logic [15:0] z);
    if (!calm) begin
      while ($urandom_range(99) < 8) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    qw <= w; qx <= x; qy <= y; qz <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    angles_due.push_back(euler_of(longint'($signed(w)), longint'($signed(x)),
                                  longint'($signed(y)), longint'($signed(z))));
  endtask

  task automatic idle_line();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Check each done strobe against the oldest prediction
  always @(posedge clk) begin
    angles_t want;
    if (!rst && done) begin
      if (angles_due.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        want = angles_due.pop_front();
        if (roll !== want.roll) report_mismatch("roll", roll, want.roll);
        if (pitch !== want.pitch) report_mismatch("pitch", pitch, want.pitch);
        if (yaw !== want.yaw) report_mismatch("yaw", yaw, want.yaw);
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic test_corners();
    logic [15:0] ext[4];
    ext = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    // axis-aligned unit quaternions and the negatives of the w and y ones
    send_quat(16'h7FFF, 0, 0, 0);
    send_quat(0, 16'h7FFF, 0, 0);
    send_quat(0, 0, 16'h7FFF, 0);
    send_quat(0, 0, 0, 16'h7FFF);
    send_quat(16'h8000, 0, 0, 0);
    send_quat(0, 0, 16'h8000, 0);
    // zero quaternion: the y arguments of the roll and yaw arctangents vanish
    send_quat(0, 0, 0, 0);
    // pitch near gimbal lock, both signs
    send_quat(16'h5A82, 0, 16'h5A82, 0);
    send_quat(16'h5A82, 0, 16'hA57E, 0);
    // unnormalized, the first with its pitch radicand driven negative
    send_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
    send_quat(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
    for (int i = 0; i < 4; i++)
      send_quat(ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4], ext[(i + 3) % 4]);
    for (int i = 0; i < 4; i++) send_quat(ext[i], ext[i], ext[i], ext[i]);
    idle_line();
  endtask

  // Near-unit quaternions from random angles, plus raw noise
  task automatic test_random(input int count);
    real a, b, c, n;
    real v[4];
    for (int k = 0; k < count; k++) begin
      calm = (k >= 300 && k < 450);
      if ($urandom_range(3) == 0) begin
        send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        a = (real'($urandom_range(20000)) - 10000.0) / 3183.0;
        b = (real'($urandom_range(20000)) - 10000.0) / 3183.0;
        c = (real'($urandom_range(20000)) - 10000.0) / 3183.0;
        v[0] = $cos(a) * $cos(b) * $cos(c) + $sin(a) * $sin(b) * $sin(c);
        v[1] = $sin(a) * $cos(b) * $cos(c) - $cos(a) * $sin(b) * $sin(c);
        v[2] = $cos(a) * $sin(b) * $cos(c) + $sin(a) * $cos(b) * $sin(c);
        v[3] = $cos(a) * $cos(b) * $sin(c) - $sin(a) * $sin(b) * $cos(c);
        n = 32767.0 * (0.97 + $urandom_range(60) / 1000.0);
        for (int j = 0; j < 4; j++) begin
          v[j] = v[j] * n;
          if (v[j] > 32767.0) v[j] = 32767.0;
          if (v[j] < -32768.0) v[j] = -32768.0;
        end
        send_quat(16'($rtoi(v[0])), 16'($rtoi(v[1])),
                  16'($rtoi(v[2])), 16'($rtoi(v[3])));
      end
    end
    calm = 1'b0;
    idle_line();
  endtask

  // Hold off the sender until the pipeline drains
  task automatic test_drain_pause();
    while (angles_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    qw = '0; qx = '0; qy = '0; qz = '0;
    mismatch_cnt = 0;
    cycle_cnt = 0;
    calm = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corners();
    test_drain_pause();
    test_random(1030);
    while (angles_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
